@@ design/strip_column_scanner_top_macros.svh @@
// Assertion macros shared by the strip column scanner modules.
`ifndef STRIP_COLUMN_SCANNER_TOP_MACROS_SVH
`define STRIP_COLUMN_SCANNER_TOP_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define SCX_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("scanner assertion failed");

// A consequence that holds in the same cycle as its cause.
`define SCX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// A consequence that holds in the cycle after its cause.
`define SCX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

@@ design/scx_pkg.sv @@
// Types, codes and helpers shared by the strip column scanner modules.
`timescale 1ns / 1ps
package scx_pkg;

    localparam int COORD_BITS = 14;

    // Input command codes.
    localparam logic [2:0] CMD_START      = 3'd0;
    localparam logic [2:0] CMD_SCAN_LEFT  = 3'd1;
    localparam logic [2:0] CMD_SCAN_RIGHT = 3'd2;
    localparam logic [2:0] CMD_MOVE_LEFT  = 3'd3;
    localparam logic [2:0] CMD_MOVE_RIGHT = 3'd4;

    // Classified command kinds.
    localparam logic [1:0] K_START = 2'd0;
    localparam logic [1:0] K_SCAN  = 2'd1;
    localparam logic [1:0] K_MOVE  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_POINT = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_OUT   = 3'd2;
    localparam logic [2:0] ST_MOVED = 3'd3;
    localparam logic [2:0] ST_TRUNC = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LINE_A = 3'd0;
    localparam logic [2:0] CFG_LINE_B = 3'd1;
    localparam logic [2:0] CFG_LOWER  = 3'd2;
    localparam logic [2:0] CFG_UPPER  = 3'd3;
    localparam logic [2:0] CFG_XMIN   = 3'd4;
    localparam logic [2:0] CFG_XMAX   = 3'd5;
    localparam logic [2:0] CFG_YMIN   = 3'd6;
    localparam logic [2:0] CFG_YMAX   = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic        right;
        logic [13:0] cx;
        logic [13:0] cy;
        logic [12:0] skip;
    } t_cmd;

    typedef struct packed {
        logic [12:0] a;
        logic [12:0] b;
        logic [26:0] lo;
        logic [26:0] hi;
        logic [12:0] xmin;
        logic [12:0] xmax;
        logic [12:0] ymin;
        logic [12:0] ymax;
    } t_cfg;

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [16:0] v);
        logic signed [16:0] hi_lim;
        logic signed [16:0] lo_lim;
        hi_lim = 17'((1 << (COORD_BITS - 1)) - 1);
        lo_lim = -hi_lim - 17'sd1;
        if (v > hi_lim) begin
            return hi_lim[COORD_BITS-1:0];
        end else if (v < lo_lim) begin
            return lo_lim[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

endpackage

@@ design/scx_front.sv @@
// Command front end: accepts commands, classifies them and queues them.
`timescale 1ns / 1ps
module scx_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_command,
    input  logic [13:0]   i_center_x,
    input  logic [13:0]   i_center_y,
    input  logic [12:0]   i_skip,
    output logic          o_q_valid,
    output scx_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);
    import scx_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_known;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    always_comb begin
        w_known = 1'b1;
        w_cmd.kind = K_START;
        w_cmd.right = 1'b0;
        w_cmd.cx = i_center_x;
        w_cmd.cy = i_center_y;
        w_cmd.skip = i_skip;
        case (i_command)
            CMD_START: begin
                w_cmd.kind = K_START;
            end
            CMD_SCAN_LEFT: begin
                w_cmd.kind = K_SCAN;
            end
            CMD_SCAN_RIGHT: begin
                w_cmd.kind = K_SCAN;
                w_cmd.right = 1'b1;
            end
            CMD_MOVE_LEFT: begin
                w_cmd.kind = K_MOVE;
            end
            CMD_MOVE_RIGHT: begin
                w_cmd.kind = K_MOVE;
                w_cmd.right = 1'b1;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign o_ready   = (r_count != 2'd2);
    assign w_push    = i_valid && o_ready && w_known;
    assign w_pop     = i_q_pop && (r_count != 2'd0);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

`include "strip_column_scanner_top_macros.svh"
    `SCX_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, r_count <= 2'd2)
    `SCX_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 2'd1)
    `SCX_ASSERT_IMP(a_known_only, i_clk, i_rst_n, w_push, i_command <= CMD_MOVE_RIGHT)

endmodule

@@ design/scx_back.sv @@
// Command back end: cursor arithmetic, row refit and column emission.
`timescale 1ns / 1ps
module scx_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  scx_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  scx_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [13:0]   o_point_x,
    output logic [13:0]   o_point_y,
    output logic [2:0]    o_status,
    output logic          o_last
);
    import scx_pkg::*;

    localparam int NW = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AX    = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_SETC  = 4'd3;
    localparam logic [3:0] S_STEST = 4'd4;
    localparam logic [3:0] S_LINIT = 4'd5;
    localparam logic [3:0] S_UP    = 4'd6;
    localparam logic [3:0] S_DOWN  = 4'd7;
    localparam logic [3:0] S_SKIP  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;
    localparam logic [3:0] S_OUT1  = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [1:0]          r_kind, n_kind;
    logic                r_right, n_right;
    logic signed [15:0]  r_x, n_x;
    logic signed [15:0]  r_y, n_y;
    logic signed [28:0]  r_ax, n_ax;
    logic signed [31:0]  r_lin, n_lin;
    logic signed [16:0]  r_r, n_r;
    logic [3:0]          r_k, n_k;
    logic signed [15:0]  r_ystart, n_ystart;
    logic signed [15:0]  r_py, n_py;
    logic [NW-1:0]       r_n, n_n;
    logic                r_have, n_have;
    logic [2:0]          r_st1, n_st1;
    logic [13:0]         r_lcol, n_lcol, r_lrow, n_lrow;
    logic [13:0]         r_rcol, n_rcol, r_rrow, n_rrow;
    logic                r_ovalid;
    logic [13:0]         r_ox, r_oy;
    logic [2:0]          r_ost;
    logic                r_olast;

    logic                w_load;
    logic [13:0]         w_lx, w_ly;
    logic [2:0]          w_lst;
    logic                w_llast;
    logic                w_free;

    logic signed [12:0]  w_a, w_b;
    logic signed [31:0]  w_lo, w_hi;
    logic signed [15:0]  w_ymin, w_ymax, w_ytop, w_xmin, w_xmax;
    logic signed [28:0]  w_axp;
    logic signed [16:0]  w_step, w_cand, w_mop;
    logic signed [29:0]  w_by;
    logic signed [31:0]  w_sum;
    logic                w_fit;
    logic signed [15:0]  w_col, w_row, w_skip, w_nc, w_ncm;
    logic                w_outside, w_cond;
    logic [13:0]         w_ysat;

    assign w_free = !r_ovalid || i_ready;
    assign w_a    = $signed(i_cfg.a);
    assign w_b    = $signed(i_cfg.b);
    assign w_lo   = 32'($signed(i_cfg.lo));
    assign w_hi   = 32'($signed(i_cfg.hi));
    assign w_xmin = $signed({3'b000, i_cfg.xmin});
    assign w_xmax = $signed({3'b000, i_cfg.xmax});
    assign w_ymin = $signed({3'b000, i_cfg.ymin});
    assign w_ymax = $signed({3'b000, i_cfg.ymax});
    assign w_ytop = w_ymax - 16'sd1;

    assign w_axp  = 29'(w_a) * 29'(r_x);
    assign w_step = $signed(17'(17'd1 << r_k));
    assign w_cand = r_r + w_step;
    assign w_mop  = (r_state == S_SRCH) ? w_cand : 17'(r_y);
    assign w_by   = 30'(w_b) * 30'(w_mop);
    assign w_sum  = 32'(r_ax) + 32'(w_by);
    assign w_fit  = (w_cand <= 17'(r_y)) && (w_sum <= w_lo);
    assign w_cond = (r_lin <= w_hi) && (r_y < w_ymax);
    assign w_ysat = sat_coord((w_sum <= w_lo) ? 17'(r_y)
                                              : -17'sd1 <<< (COORD_BITS - 1));

    assign w_col  = 16'($signed(i_q_cmd.right ? r_rcol : r_lcol));
    assign w_row  = 16'($signed(i_q_cmd.right ? r_rrow : r_lrow));
    assign w_skip = $signed({3'b000, i_q_cmd.skip});
    assign w_nc   = i_q_cmd.right ? (w_col + w_skip) : (w_col - w_skip);
    assign w_ncm  = i_q_cmd.right ? (w_col + w_skip - 16'sd1) : (w_col - w_skip + 16'sd1);
    assign w_outside = i_q_cmd.right ? (w_nc >= w_xmax) : (w_nc < w_xmin);

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        n_kind = r_kind;
        n_right = r_right;
        n_x = r_x;
        n_y = r_y;
        n_ax = r_ax;
        n_lin = r_lin;
        n_r = r_r;
        n_k = r_k;
        n_ystart = r_ystart;
        n_py = r_py;
        n_n = r_n;
        n_have = r_have;
        n_st1 = r_st1;
        n_lcol = r_lcol;
        n_lrow = r_lrow;
        n_rcol = r_rcol;
        n_rrow = r_rrow;
        w_load = 1'b0;
        w_lx = r_x[13:0];
        w_ly = r_py[13:0];
        w_lst = ST_POINT;
        w_llast = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_kind = i_q_cmd.kind;
                    n_right = i_q_cmd.right;
                    n_have = 1'b0;
                    n_n = '0;
                    case (i_q_cmd.kind)
                        K_START: begin
                            n_x = 16'($signed(i_q_cmd.cx));
                            n_y = 16'($signed(i_q_cmd.cy)) - 16'sd1;
                            n_state = S_AX;
                        end
                        K_SCAN: begin
                            if (i_q_cmd.right) begin
                                n_rcol = sat_coord(17'(w_nc));
                            end else begin
                                n_lcol = sat_coord(17'(w_nc));
                            end
                            n_x = 16'($signed(sat_coord(17'(w_nc))));
                            n_y = w_row;
                            if (w_outside) begin
                                n_st1 = ST_OUT;
                                n_state = S_OUT1;
                            end else begin
                                n_state = S_AX;
                            end
                        end
                        default: begin
                            if (i_q_cmd.right) begin
                                n_rcol = sat_coord(17'(w_ncm));
                            end else begin
                                n_lcol = sat_coord(17'(w_ncm));
                            end
                            n_x = 16'($signed(sat_coord(17'(w_ncm))));
                            n_y = w_row;
                            n_st1 = ST_MOVED;
                            n_state = S_OUT1;
                        end
                    endcase
                end
            end
            S_AX: begin
                n_ax = w_axp;
                n_r = -17'sd1 <<< (COORD_BITS - 1);
                n_k = 4'(COORD_BITS);
                if (r_kind == K_SCAN) begin
                    n_state = S_LINIT;
                end else if (w_b > 13'sd0) begin
                    n_state = S_SRCH;
                end else begin
                    n_state = S_STEST;
                end
            end
            S_SRCH: begin
                if (w_fit) begin
                    n_r = w_cand;
                end
                n_k = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_state = S_SETC;
                end
            end
            S_SETC: begin
                n_y = 16'(r_r);
                n_lcol = r_x[13:0];
                n_rcol = r_x[13:0];
                n_lrow = sat_coord(r_r);
                n_rrow = sat_coord(r_r);
                n_state = S_LINIT;
            end
            S_STEST: begin
                n_y = 16'($signed(w_ysat));
                n_lcol = r_x[13:0];
                n_rcol = r_x[13:0];
                n_lrow = w_ysat;
                n_rrow = w_ysat;
                n_state = S_LINIT;
            end
            S_LINIT: begin
                n_lin = w_sum;
                n_ystart = r_y;
                n_state = (r_kind == K_SCAN) ? S_UP : S_SKIP;
            end
            S_UP: begin
                if ((r_y < w_ytop) && (r_lin < w_lo)) begin
                    n_y = r_y + 16'sd1;
                    n_lin = r_lin + 32'(w_b);
                end else begin
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                if ((r_y > w_ymin) && (r_lin > w_lo)) begin
                    n_y = r_y - 16'sd1;
                    n_lin = r_lin - 32'(w_b);
                end else begin
                    if (r_right) begin
                        n_rrow = sat_coord(17'(r_y));
                    end else begin
                        n_lrow = sat_coord(17'(r_y));
                    end
                    n_ystart = r_y;
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if ((r_y < w_ymin) && (r_lin <= w_hi)) begin
                    n_y = r_y + 16'sd1;
                    n_lin = r_lin + 32'(w_b);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_free) begin
                    if (w_cond) begin
                        if (r_have && (r_n == NW'(MAX_POINTS))) begin
                            w_load = 1'b1;
                            w_lst = ST_TRUNC;
                            w_llast = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            w_load = r_have;
                            n_have = 1'b1;
                            n_py = r_y;
                            n_n = r_n + NW'(1);
                            n_y = r_y + 16'sd1;
                            n_lin = r_lin + 32'(w_b);
                        end
                    end else begin
                        w_load = 1'b1;
                        w_llast = 1'b1;
                        if (!r_have) begin
                            w_ly = r_ystart[13:0];
                            w_lst = ST_EMPTY;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT1: begin
                if (w_free) begin
                    w_load = 1'b1;
                    w_ly = r_y[13:0];
                    w_lst = r_st1;
                    w_llast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have <= 1'b0;
            r_n <= '0;
            r_lcol <= '0;
            r_lrow <= '0;
            r_rcol <= '0;
            r_rrow <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_have <= n_have;
            r_n <= n_n;
            r_lcol <= n_lcol;
            r_lrow <= n_lrow;
            r_rcol <= n_rcol;
            r_rrow <= n_rrow;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_right <= n_right;
        r_x <= n_x;
        r_y <= n_y;
        r_ax <= n_ax;
        r_lin <= n_lin;
        r_r <= n_r;
        r_k <= n_k;
        r_ystart <= n_ystart;
        r_py <= n_py;
        r_st1 <= n_st1;
        if (w_load) begin
            r_ox <= w_lx;
            r_oy <= w_ly;
            r_ost <= w_lst;
            r_olast <= w_llast;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_point_x = r_ox;
    assign o_point_y = r_oy;
    assign o_status  = r_ost;
    assign o_last    = r_olast;

`include "strip_column_scanner_top_macros.svh"
    `SCX_ASSERT_NOW(a_n_bound, i_clk, i_rst_n, r_n <= NW'(MAX_POINTS))
    `SCX_ASSERT_IMP(a_pend_count, i_clk, i_rst_n, (r_state == S_EMIT) && r_have, r_n != '0)
    `SCX_ASSERT_IMP(a_refit_scan, i_clk, i_rst_n, (r_state == S_UP) || (r_state == S_DOWN), r_kind == K_SCAN)

endmodule

@@ design/strip_column_scanner_top.sv @@
// Top level of the strip column scanner: configuration registers and the two halves.
`timescale 1ns / 1ps
// Commands enter through a two-deep queue, so up to two may be accepted while the
// previous one is still running. A move-only command or an out-of-image scan goes
// from idle straight to its single result. A scan sets up its terms, then walks
// the cursor row by row to re-fit it to the lower line, skips the rows below
// window_ymin and then emits the column pixel by pixel. A start command replaces
// the walk by a bit-by-bit search of the row when line_b is positive. The row walk
// and the one-pixel-per-cycle emission, while the output is free, set the rate;
// the output register takes one result per cycle when the sink is ready.
module strip_column_scanner_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // center_x[13:0], center_y[27:14], skip_amount[40:28]
    input  logic [2:0]  i_s_axis_tuser,  // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // point_x[13:0], point_y[27:14]
    output logic [2:0]  o_m_axis_tuser,  // status
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [26:0] i_cfg_data
);
    import scx_pkg::*;

    logic [12:0] r_a, r_b, r_xmin, r_xmax, r_ymin, r_ymax;
    logic [26:0] r_lower, r_upper;
    t_cfg        w_cfg;
    logic        w_q_valid;
    t_cmd        w_q_cmd;
    logic        w_q_pop;
    logic [13:0] w_px, w_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= 13'd0;
            r_b <= 13'd1;
            r_lower <= 27'd0;
            r_upper <= 27'd0;
            r_xmin <= 13'd0;
            r_xmax <= 13'd4096;
            r_ymin <= 13'd0;
            r_ymax <= 13'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_A: r_a <= i_cfg_data[12:0];
                CFG_LINE_B: r_b <= i_cfg_data[12:0];
                CFG_LOWER:  r_lower <= i_cfg_data;
                CFG_UPPER:  r_upper <= i_cfg_data;
                CFG_XMIN:   r_xmin <= i_cfg_data[12:0];
                CFG_XMAX:   r_xmax <= i_cfg_data[12:0];
                CFG_YMIN:   r_ymin <= i_cfg_data[12:0];
                CFG_YMAX:   r_ymax <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.a = r_a;
        w_cfg.b = r_b;
        w_cfg.xmin = r_xmin;
        w_cfg.xmax = r_xmax;
        w_cfg.ymin = r_ymin;
        w_cfg.ymax = r_ymax;
        if ($signed(r_upper) < $signed(r_lower)) begin
            w_cfg.lo = r_upper;
            w_cfg.hi = r_lower;
        end else begin
            w_cfg.lo = r_lower;
            w_cfg.hi = r_upper;
        end
    end

    scx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_command  (i_s_axis_tuser),
        .i_center_x (i_s_axis_tdata[13:0]),
        .i_center_y (i_s_axis_tdata[27:14]),
        .i_skip     (i_s_axis_tdata[40:28]),
        .o_q_valid  (w_q_valid),
        .o_q_cmd    (w_q_cmd),
        .i_q_pop    (w_q_pop)
    );

    scx_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_point_x (w_px),
        .o_point_y (w_py),
        .o_status  (o_m_axis_tuser),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0000, w_py, w_px};

endmodule
